// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL; the allocator core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PBA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pba_pkg.sv -----
package pba_pkg;

    // Default sizing of the allocator
    localparam int DEF_BUCKET_COUNT   = 12;
    localparam int DEF_SMALLEST_BYTES = 8;
    localparam int DEF_MAX_BLOCKS     = 1024;
    localparam int DEF_HEADER_BYTES   = 6;

    // Field widths
    localparam int HDL_W     = 10;
    localparam int ADDR_W    = 16;
    localparam int SIZE_W    = 16;
    localparam int BKT_W     = 4;
    localparam int CAPO_W    = 15;
    localparam int CAP_MAX_W = 22;
    localparam int SMALL_W   = 7;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_RESIZE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TOO_BIG = 3'd1,
        ST_OOM     = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_BAD     = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_START = 2'd0,
        CFG_HEAP_END   = 2'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OLD,
        S_ALLOC,
        S_POP,
        S_PUSH,
        S_DONE
    } t_state;

    // Bucket choice for a request size
    typedef struct packed {
        logic             fit;
        logic [BKT_W-1:0] bkt;
    } t_size_info;

    // Capacity in bytes of bucket b
    function automatic logic [CAP_MAX_W-1:0] cap_of(input logic [SMALL_W-1:0] smallest,
                                                    input logic [BKT_W-1:0] b);
        cap_of = CAP_MAX_W'(smallest) << b;
    endfunction

endpackage

// ----- hw/rtl/pba_if.sv -----
// Request channel
interface pba_req_if;
    import pba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           mode;
    logic [SIZE_W-1:0]    request_bytes;
    logic [HDL_W-1:0]     block_handle;
    logic                 handle_present;

    modport source (output valid, mode, request_bytes, block_handle, handle_present,
                    input ready);
    modport sink   (input valid, mode, request_bytes, block_handle, handle_present,
                    output ready);
endinterface

// Result channel
interface pba_rsp_if;
    import pba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [HDL_W-1:0]     result_handle;
    logic [ADDR_W-1:0]    result_address;
    logic [CAPO_W-1:0]    capacity;
    logic [BKT_W-1:0]     bucket_index;
    t_status              status;

    modport source (output valid, result_handle, result_address, capacity, bucket_index,
                    status, input ready);
    modport sink   (input valid, result_handle, result_address, capacity, bucket_index,
                    status, output ready);
endinterface

// Configuration write channel
interface pba_cfg_if;
    import pba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [ADDR_W-1:0]    wr_data;

    modport source (output valid, wr_index, wr_data, input ready);
    modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

// ----- hw/rtl/pba_sizer.sv -----
module pba_sizer #(
    parameter int BUCKET_COUNT   = pba_pkg::DEF_BUCKET_COUNT,
    parameter int SMALLEST_BYTES = pba_pkg::DEF_SMALLEST_BYTES
) (
    input  logic [pba_pkg::SIZE_W-1:0] i_bytes,
    output pba_pkg::t_size_info        o_size
);
    import pba_pkg::*;

    // Pick the smallest bucket whose capacity holds the request
    always_comb begin
        o_size = '0;
        for (int b = BUCKET_COUNT - 1; b >= 0; b--) begin
            if (CAP_MAX_W'(i_bytes) <= cap_of(SMALL_W'(SMALLEST_BYTES), BKT_W'(b))) begin
                o_size.fit = 1'b1;
                o_size.bkt = BKT_W'(b);
            end
        end
    end

endmodule

// ----- hw/rtl/power_of_two_bucket_allocator_core.sv -----
// Channel   Dir  Handshake          Payload
// i_cfg     in   valid/ready        wr_index, wr_data (heap_start, heap_end)
// i_req     in   valid/ready        mode, request_bytes, block_handle, handle_present
// o_rsp     out  valid/ready        result_handle, result_address, capacity,
//                                   bucket_index, status
//
// One item at a time, one result per item. Unknown handle, unused mode and null free go
// straight to S_DONE; free, double free and a resize that fits pass S_OLD; carve, too big
// and out of memory pass S_ALLOC; a pop adds S_POP; a moving resize adds S_PUSH as well.
// The block table reads then writes back. A new item is taken while the previous result waits
// in the output register; a stalled output adds cycles only while that register is still full.
// Reset empties every free list and zeroes the break pointer; configuration is always ready.
`include "assert_macros.svh"

module power_of_two_bucket_allocator_core #(
    parameter int BUCKET_COUNT   = pba_pkg::DEF_BUCKET_COUNT,
    parameter int SMALLEST_BYTES = pba_pkg::DEF_SMALLEST_BYTES,
    parameter int MAX_BLOCKS     = pba_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES   = pba_pkg::DEF_HEADER_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pba_cfg_if.sink   i_cfg,
    pba_req_if.sink   i_req,
    pba_rsp_if.source o_rsp
);
    import pba_pkg::*;

    localparam int HW     = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = HW + 1;
    localparam int BKT_IW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int SUM_W  = CAP_MAX_W + 1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic              live;
        logic [BKT_W-1:0]  bkt;
        logic              nvld;
        logic [HW-1:0]     next;
    } t_ent;

    // Sequencer and request registers
    t_state             r_state, n_state;
    logic [1:0]         r_mode;
    logic [SIZE_W-1:0]  r_bytes;
    logic [HW-1:0]      r_hdl;
    logic               r_present;
    t_size_info         r_sz;
    logic [HW-1:0]      r_nb;
    logic [BKT_W-1:0]   r_old_bkt;
    logic [ADDR_W-1:0]  r_old_start;

    // Free-list heads, break pointer, carve count, heap limit
    logic [HW-1:0]           r_head_hdl [BUCKET_COUNT];
    logic [BUCKET_COUNT-1:0] r_head_vld;
    logic [ADDR_W-1:0]       r_bp;
    logic [ADDR_W-1:0]       r_heap_end;
    logic [CNT_W-1:0]        r_carved;

    // Block table
    t_ent r_mem [MAX_BLOCKS];
    t_ent r_rdata;

    // Staged result and output register
    logic [HW-1:0]     r_res_hdl,  n_res_hdl;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [CAPO_W-1:0] r_res_cap,  n_res_cap;
    logic [BKT_W-1:0]  r_res_bkt,  n_res_bkt;
    t_status           r_res_st,   n_res_st;
    logic              r_out_valid;
    logic [HW-1:0]     r_out_hdl;
    logic [ADDR_W-1:0] r_out_addr;
    logic [CAPO_W-1:0] r_out_cap;
    logic [BKT_W-1:0]  r_out_bkt;
    t_status           r_out_st;

    // Combinational controls
    logic                 w_acc;
    logic                 w_cfg_acc;
    logic [HW-1:0]        w_in_hdl;
    logic                 w_in_known;
    t_size_info           w_in_sz;
    logic                 w_push_old;
    logic [BKT_IW-1:0]    w_hsel;
    logic [HW-1:0]        w_head_hdl;
    logic                 w_head_vld;
    logic [CAP_MAX_W-1:0] w_cap_rd;
    logic [CAP_MAX_W-1:0] w_cap_new;
    logic                 w_fits;
    logic [SUM_W-1:0]     w_top;
    logic                 w_oom;
    logic                 w_out_free;
    logic                 w_mem_re;
    logic [HW-1:0]        w_mem_raddr;
    logic                 w_mem_we;
    logic [HW-1:0]        w_mem_waddr;
    t_ent                 w_mem_wdata;
    logic                 w_head_we;
    logic [HW-1:0]        w_head_wr_hdl;
    logic                 w_head_wr_vld;
    logic                 w_carve;
    logic                 w_out_load;

    pba_sizer #(
        .BUCKET_COUNT   (BUCKET_COUNT),
        .SMALLEST_BYTES (SMALLEST_BYTES)
    ) u_sizer (
        .i_bytes (i_req.request_bytes),
        .o_size  (w_in_sz)
    );

    // Handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    assign w_in_hdl   = HW'(i_req.block_handle);
    assign w_in_known = ({1'b0, w_in_hdl} < r_carved);
    assign w_push_old = (r_mode == MODE_RESIZE) && r_present;

    // Select the free-list head for this cycle
    always_comb begin
        case (r_state)
            S_OLD:   w_hsel = BKT_IW'(r_rdata.bkt);
            S_PUSH:  w_hsel = BKT_IW'(r_old_bkt);
            default: w_hsel = BKT_IW'(r_sz.bkt);
        endcase
    end
    assign w_head_hdl = r_head_hdl[w_hsel];
    assign w_head_vld = r_head_vld[w_hsel];

    // Capacity checks and break arithmetic
    assign w_cap_rd  = cap_of(SMALL_W'(SMALLEST_BYTES), r_rdata.bkt);
    assign w_cap_new = cap_of(SMALL_W'(SMALLEST_BYTES), r_sz.bkt);
    assign w_fits    = (CAP_MAX_W'(r_bytes) <= w_cap_rd);
    assign w_top     = SUM_W'(r_bp) + SUM_W'(w_cap_new) + SUM_W'(HEADER_BYTES);
    assign w_oom     = (r_carved == CNT_W'(MAX_BLOCKS)) || (w_top > SUM_W'(r_heap_end));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_req.mode)
                        MODE_ALLOC: n_state = S_ALLOC;
                        MODE_FREE, MODE_RESIZE: begin
                            if (i_req.handle_present) begin
                                n_state = w_in_known ? S_OLD : S_DONE;
                            end else begin
                                n_state = (i_req.mode == MODE_RESIZE) ? S_ALLOC : S_DONE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_OLD: begin
                if (!r_rdata.live || r_mode == MODE_FREE || w_fits) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (!r_sz.fit) begin
                    n_state = S_DONE;
                end else if (w_head_vld) begin
                    n_state = S_POP;
                end else if (w_oom) begin
                    n_state = S_DONE;
                end else begin
                    n_state = w_push_old ? S_PUSH : S_DONE;
                end
            end
            S_POP:   n_state = w_push_old ? S_PUSH : S_DONE;
            S_PUSH:  n_state = S_DONE;
            S_DONE:  n_state = w_out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Memory, list and result controls
    always_comb begin
        w_mem_re      = 1'b0;
        w_mem_raddr   = w_in_hdl;
        w_mem_we      = 1'b0;
        w_mem_waddr   = r_hdl;
        w_mem_wdata   = '0;
        w_head_we     = 1'b0;
        w_head_wr_hdl = r_hdl;
        w_head_wr_vld = 1'b1;
        w_carve       = 1'b0;
        w_out_load    = 1'b0;
        n_res_hdl     = r_res_hdl;
        n_res_addr    = r_res_addr;
        n_res_cap     = r_res_cap;
        n_res_bkt     = r_res_bkt;
        n_res_st      = r_res_st;
        case (r_state)
            S_IDLE: begin
                // fetch the named block; stage the result of the trivial cases
                if (w_acc) begin
                    w_mem_re   = 1'b1;
                    n_res_hdl  = '0;
                    n_res_addr = '0;
                    n_res_cap  = '0;
                    n_res_bkt  = '0;
                    n_res_st   = (i_req.mode == MODE_FREE && !i_req.handle_present) ?
                                 ST_OK : ST_BAD;
                end
            end
            S_OLD: begin
                n_res_hdl  = r_hdl;
                n_res_addr = r_rdata.start + ADDR_W'(HEADER_BYTES);
                n_res_cap  = CAPO_W'(w_cap_rd);
                n_res_bkt  = r_rdata.bkt;
                n_res_st   = ST_OK;
                if (!r_rdata.live) begin
                    n_res_hdl  = '0;
                    n_res_addr = '0;
                    n_res_cap  = '0;
                    n_res_bkt  = '0;
                    n_res_st   = ST_DOUBLE;
                end else if (r_mode == MODE_FREE) begin
                    // push the block on its bucket list
                    w_mem_we    = 1'b1;
                    w_mem_wdata = '{start: r_rdata.start, live: 1'b0, bkt: r_rdata.bkt,
                                    nvld: w_head_vld, next: w_head_hdl};
                    w_head_we   = 1'b1;
                end
            end
            S_ALLOC: begin
                n_res_hdl  = '0;
                n_res_addr = '0;
                n_res_cap  = '0;
                n_res_bkt  = '0;
                if (!r_sz.fit) begin
                    n_res_st = ST_TOO_BIG;
                end else if (w_head_vld) begin
                    w_mem_re    = 1'b1;
                    w_mem_raddr = w_head_hdl;
                end else if (w_oom) begin
                    n_res_st = ST_OOM;
                end else begin
                    // carve a fresh block at the break
                    w_carve     = 1'b1;
                    w_mem_we    = 1'b1;
                    w_mem_waddr = r_carved[HW-1:0];
                    w_mem_wdata = '{start: r_bp, live: 1'b1, bkt: r_sz.bkt,
                                    nvld: 1'b0, next: '0};
                    n_res_hdl   = r_carved[HW-1:0];
                    n_res_addr  = r_bp + ADDR_W'(HEADER_BYTES);
                    n_res_cap   = CAPO_W'(w_cap_new);
                    n_res_bkt   = r_sz.bkt;
                    n_res_st    = ST_OK;
                end
            end
            S_POP: begin
                // advance the list head and mark the block live
                w_head_we        = 1'b1;
                w_head_wr_hdl    = r_rdata.next;
                w_head_wr_vld    = r_rdata.nvld;
                w_mem_we         = 1'b1;
                w_mem_waddr      = r_nb;
                w_mem_wdata      = r_rdata;
                w_mem_wdata.live = 1'b1;
                n_res_hdl        = r_nb;
                n_res_addr       = r_rdata.start + ADDR_W'(HEADER_BYTES);
                n_res_cap        = CAPO_W'(w_cap_rd);
                n_res_bkt        = r_rdata.bkt;
                n_res_st         = ST_OK;
            end
            S_PUSH: begin
                // release the old block after a move
                w_mem_we    = 1'b1;
                w_mem_wdata = '{start: r_old_start, live: 1'b0, bkt: r_old_bkt,
                                nvld: w_head_vld, next: w_head_hdl};
                w_head_we   = 1'b1;
            end
            S_DONE:  w_out_load = w_out_free;
            default: w_out_load = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head_vld  <= '0;
            r_bp        <= '0;
            r_carved    <= '0;
            r_heap_end  <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_head_we) begin
                r_head_vld[w_hsel] <= w_head_wr_vld;
            end
            if (w_carve) begin
                r_bp     <= w_top[ADDR_W-1:0];
                r_carved <= r_carved + CNT_W'(1);
            end else if (w_cfg_acc && i_cfg.wr_index == CFG_HEAP_START && r_carved == '0) begin
                r_bp <= i_cfg.wr_data;
            end
            if (w_cfg_acc && i_cfg.wr_index == CFG_HEAP_END) begin
                r_heap_end <= i_cfg.wr_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mode    <= i_req.mode;
            r_bytes   <= i_req.request_bytes;
            r_hdl     <= w_in_hdl;
            r_present <= i_req.handle_present;
            r_sz      <= w_in_sz;
        end
        if (r_state == S_ALLOC) begin
            r_nb <= w_head_hdl;
        end
        if (r_state == S_OLD) begin
            r_old_bkt   <= r_rdata.bkt;
            r_old_start <= r_rdata.start;
        end
        if (w_head_we) begin
            r_head_hdl[w_hsel] <= w_head_wr_hdl;
        end
        r_res_hdl  <= n_res_hdl;
        r_res_addr <= n_res_addr;
        r_res_cap  <= n_res_cap;
        r_res_bkt  <= n_res_bkt;
        r_res_st   <= n_res_st;
        if (w_out_load) begin
            r_out_hdl  <= r_res_hdl;
            r_out_addr <= r_res_addr;
            r_out_cap  <= r_res_cap;
            r_out_bkt  <= r_res_bkt;
            r_out_st   <= r_res_st;
        end
    end

    // Block table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= r_mem[w_mem_raddr];
        end
    end

    // Drive the result channel
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_handle  = HDL_W'(r_out_hdl);
    assign o_rsp.result_address = r_out_addr;
    assign o_rsp.capacity       = r_out_cap;
    assign o_rsp.bucket_index   = r_out_bkt;
    assign o_rsp.status         = r_out_st;

    `PBA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_acc, r_state != S_IDLE, "accepted item left sequencer idle")
    `PBA_ASSERT_NEXT(a_carve_counts, i_clk, i_rst_n, w_carve, r_carved == $past(r_carved) + CNT_W'(1), "carve count did not advance")
    `PBA_ASSERT_NEXT(a_done_loads_out, i_clk, i_rst_n, r_state == S_DONE && w_out_free, r_out_valid && r_state == S_IDLE, "result not handed to output register")
    `PBA_ASSERT_IMPL(a_error_payload_zero, i_clk, i_rst_n, r_out_valid && r_out_st != ST_OK, r_out_hdl == '0 && r_out_addr == '0 && r_out_cap == '0 && r_out_bkt == '0, "error result carries payload")

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    import pba_pkg::*;

    localparam int BUCKETS        = DEF_BUCKET_COUNT;
    localparam int MIN_BYTES      = DEF_SMALLEST_BYTES;
    localparam int BLOCK_LIMIT    = DEF_MAX_BLOCKS;
    localparam int HDR_BYTES      = DEF_HEADER_BYTES;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HEAP_MID_END   = 40000;

    typedef struct packed {
        logic [1:0]        mode;
        logic [SIZE_W-1:0] bytes;
        logic [HDL_W-1:0]  hdl;
        logic              present;
    } request_t;

    typedef struct packed {
        logic [HDL_W-1:0]  hdl;
        logic [ADDR_W-1:0] addr;
        logic [CAPO_W-1:0] cap;
        logic [BKT_W-1:0]  bkt;
        t_status           st;
    } reply_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pba_cfg_if cfg_if();
    pba_req_if req_if();
    pba_rsp_if rsp_if();

    power_of_two_bucket_allocator_core dut (
        .i_clk,
        .i_rst_n,
        .i_cfg (cfg_if),
        .i_req (req_if),
        .o_rsp (rsp_if)
    );

    always #1 i_clk = ~i_clk;

    // Allocator state as the block should hold it
    int unsigned heap_base  = 0;
    int unsigned heap_limit = 65535;
    int unsigned brk        = 0;
    int unsigned carved     = 0;
    bit          head_ok   [BUCKETS];
    int unsigned head_of   [BUCKETS];
    bit          link_ok   [BLOCK_LIMIT];
    int unsigned link_of   [BLOCK_LIMIT];
    int unsigned bucket_of [BLOCK_LIMIT];
    bit          is_live   [BLOCK_LIMIT];
    int unsigned base_of   [BLOCK_LIMIT];

    request_t pending_requests[$];
    reply_t   expected_replies[$];
    request_t next_req;
    reply_t   want_reply;
    int       failures = 0;

    bit          no_idle     = 1'b0;
    int unsigned hold_asked  = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left   = 0;
    int unsigned send_gap    = 0;
    int unsigned rsp_gap     = 0;
    int unsigned quiet_cycles = 0;
    bit          req_acc = 1'b0;
    bit          rsp_acc = 1'b0;

    // Smallest bucket that holds n bytes, BUCKETS if none does
    function automatic int unsigned bucket_for(int unsigned n);
        int unsigned b;
        b = 0;
        while (b < BUCKETS && n > (MIN_BYTES << b))
            b++;
        return b;
    endfunction

    // Pop a free block of the right bucket, or carve one at the break
    function automatic t_status take_block(int unsigned n, output int unsigned h);
        int unsigned b;
        int unsigned top;
        b = bucket_for(n);
        h = 0;
        if (b >= BUCKETS)
            return ST_TOO_BIG;
        if (head_ok[b]) begin
            h = head_of[b];
            head_of[b] = link_of[h];
            head_ok[b] = link_ok[h];
            is_live[h] = 1'b1;
            return ST_OK;
        end
        if (carved >= BLOCK_LIMIT)
            return ST_OOM;
        top = brk + (MIN_BYTES << b) + HDR_BYTES;
        if (top > heap_limit)
            return ST_OOM;
        h = carved;
        base_of[h]   = brk;
        bucket_of[h] = b;
        is_live[h]   = 1'b1;
        link_of[h]   = 0;
        link_ok[h]   = 1'b0;
        brk    = top;
        carved = carved + 1;
        return ST_OK;
    endfunction

    // Push a block onto the head of its bucket list
    function automatic void release_block(int unsigned h);
        int unsigned b;
        b = bucket_of[h];
        is_live[h] = 1'b0;
        link_of[h] = head_of[b];
        link_ok[h] = head_ok[b];
        head_of[b] = h;
        head_ok[b] = 1'b1;
    endfunction

    function automatic reply_t shape_reply(int unsigned h, t_status st);
        reply_t r;
        r    = '0;
        r.st = st;
        if (st == ST_OK) begin
            r.hdl  = h[HDL_W-1:0];
            r.addr = ADDR_W'(base_of[h] + HDR_BYTES);
            r.cap  = CAPO_W'(MIN_BYTES << bucket_of[h]);
            r.bkt  = BKT_W'(bucket_of[h]);
        end
        return r;
    endfunction

    // Apply one request to the state and return the reply it earns
    function automatic reply_t serve_request(request_t q);
        int unsigned nh;
        t_status     st;
        nh = 0;
        if (q.mode == MODE_ALLOC) begin
            st = take_block(q.bytes, nh);
            return shape_reply(nh, st);
        end
        if (q.mode == MODE_UNUSED)
            return shape_reply(0, ST_BAD);
        if (!q.present) begin
            // null free reports all zeroes; null resize allocates
            if (q.mode == MODE_FREE)
                return '0;
            st = take_block(q.bytes, nh);
            return shape_reply(nh, st);
        end
        if (q.hdl >= carved)
            return shape_reply(0, ST_BAD);
        if (!is_live[q.hdl])
            return shape_reply(0, ST_DOUBLE);
        if (q.mode == MODE_FREE) begin
            release_block(q.hdl);
            return shape_reply(q.hdl, ST_OK);
        end
        if (q.bytes <= (MIN_BYTES << bucket_of[q.hdl]))
            return shape_reply(q.hdl, ST_OK);
        // move: old block goes back only if the new one was found
        st = take_block(q.bytes, nh);
        if (st == ST_OK)
            release_block(q.hdl);
        return shape_reply(nh, st);
    endfunction

    function automatic void issue(logic [1:0] m, int unsigned n, int unsigned h, bit p);
        request_t q;
        q.mode    = m;
        q.bytes   = n[SIZE_W-1:0];
        q.hdl     = h[HDL_W-1:0];
        q.present = p;
        expected_replies.push_back(serve_request(q));
        pending_requests.push_back(q);
    endfunction

    // Mostly valid handles and small sizes, with noise on top
    function automatic void issue_random();
        int unsigned pick;
        int unsigned n;
        int unsigned h;
        int unsigned b;
        bit          p;
        logic [1:0]  m;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            m = MODE_ALLOC;
        else if (pick < 70)
            m = MODE_FREE;
        else if (pick < 97)
            m = MODE_RESIZE;
        else
            m = MODE_UNUSED;
        p = ($urandom_range(0, 99) >= 8);

        h = $urandom_range(0, 1023);
        pick = $urandom_range(0, 99);
        if (carved > 0 && pick < 90) begin
            h = $urandom_range(0, carved - 1);
            if (pick < 80)
                for (int k = 0; k < 16 && !is_live[h]; k++)
                    h = $urandom_range(0, carved - 1);
        end

        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            n = $urandom_range(0, 64);
        end else if (pick < 80) begin
            n = $urandom_range(0, 1024);
        end else if (pick < 92) begin
            n = $urandom_range(0, 16384);
        end else if (pick < 97) begin
            b = $urandom_range(0, BUCKETS - 1);
            n = (MIN_BYTES << b) + $urandom_range(0, 1);
        end else begin
            n = $urandom_range(0, 65535);
        end
        issue(m, n, h, p);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Request driver: offer one item, hold it until taken, then idle for a random gap that may be zero
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid          <= 1'b0;
            req_if.mode           <= MODE_ALLOC;
            req_if.request_bytes  <= '0;
            req_if.block_handle   <= '0;
            req_if.handle_present <= 1'b0;
        end else if (!req_if.valid || req_acc) begin
            if (send_gap > 0) begin
                send_gap     <= send_gap - 1;
                req_if.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                next_req = pending_requests.pop_front();
                req_if.mode           <= next_req.mode;
                req_if.request_bytes  <= next_req.bytes;
                req_if.block_handle   <= next_req.hdl;
                req_if.handle_present <= next_req.present;
                req_if.valid          <= 1'b1;
                send_gap              <= pick_gap();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Result sink: random stalls, plus a long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else if (hold_asked != hold_served) begin
            hold_served  <= hold_served + 1;
            hold_left    <= LONG_HOLD;
            rsp_if.ready <= 1'b0;
        end else if (rsp_gap > 0) begin
            rsp_gap      <= rsp_gap - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
            if (rsp_acc || $urandom_range(0, 9) == 0)
                rsp_gap <= pick_gap();
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        req_acc <= i_rst_n && req_if.valid && req_if.ready;
        rsp_acc <= i_rst_n && rsp_if.valid && rsp_if.ready;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_replies.size() == 0) begin
                $error("result item with no request outstanding");
                failures++;
            end else begin
                want_reply = expected_replies.pop_front();
                check_field("result_handle", want_reply.hdl, rsp_if.result_handle);
                check_field("result_address", want_reply.addr, rsp_if.result_address);
                check_field("capacity", want_reply.cap, rsp_if.capacity);
                check_field("bucket_index", want_reply.bkt, rsp_if.bucket_index);
                check_field("status", want_reply.st, rsp_if.status);
            end
        end
    end

    // Watchdog: stop when no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
                || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL power_of_two_bucket_allocator_core");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_reg idx, logic [15:0] val);
        @(negedge i_clk);
        cfg_if.valid    <= 1'b1;
        cfg_if.wr_index <= idx;
        cfg_if.wr_data  <= val;
        @(posedge i_clk);
        while (!(cfg_if.valid && cfg_if.ready))
            @(posedge i_clk);
        if (idx == CFG_HEAP_START) begin
            heap_base = val;
            if (carved == 0)
                brk = val;
        end else begin
            heap_limit = val;
        end
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Wait until every item is sent and answered, then let the block settle
    task automatic wait_idle();
        while (pending_requests.size() > 0 || expected_replies.size() > 0 || req_if.valid)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        cfg_if.valid          = 1'b0;
        cfg_if.wr_index       = CFG_HEAP_START;
        cfg_if.wr_data        = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // heap too small for even the smallest block
        write_reg(CFG_HEAP_START, 16'hFFFF);
        write_reg(CFG_HEAP_END, 16'h0000);
        issue(MODE_ALLOC, 0, 0, 0);
        issue(MODE_ALLOC, 16384, 0, 0);
        issue(MODE_RESIZE, 8, 0, 0);
        wait_idle();

        // break at the top of the address space still overflows
        write_reg(CFG_HEAP_END, 16'hFFFF);
        issue(MODE_ALLOC, 1, 0, 0);
        issue(MODE_FREE, 0, 0, 1);
        issue(MODE_FREE, 0, 0, 0);
        issue(MODE_UNUSED, 0, 0, 0);
        wait_idle();

        // directed walk through lists, resize and errors
        write_reg(CFG_HEAP_START, 16'h0000);
        write_reg(CFG_HEAP_END, 16'(HEAP_MID_END));
        issue(MODE_ALLOC, 0, 0, 0);
        issue(MODE_ALLOC, 9, 0, 0);
        issue(MODE_ALLOC, 16384, 0, 0);
        issue(MODE_ALLOC, 16385, 0, 0);
        issue(MODE_ALLOC, 65535, 1023, 1);
        issue(MODE_FREE, 0, 0, 1);
        issue(MODE_FREE, 0, 0, 1);
        issue(MODE_RESIZE, 8, 0, 1);
        issue(MODE_ALLOC, 8, 0, 0);
        issue(MODE_RESIZE, 16, 1, 1);
        issue(MODE_RESIZE, 17, 1, 1);
        issue(MODE_FREE, 0, 1023, 1);
        issue(MODE_RESIZE, 100, 1023, 1);
        issue(MODE_RESIZE, 40000, 3, 1);
        issue(MODE_ALLOC, 16384, 0, 0);
        issue(MODE_ALLOC, 16384, 0, 0);
        issue(MODE_RESIZE, 10000, 2, 1);
        issue(MODE_RESIZE, 16384, 3, 1);
        wait_idle();

        // back-to-back items against a long output stall
        no_idle = 1'b1;
        hold_asked++;
        repeat (60) issue_random();
        wait_idle();
        no_idle = 1'b0;
        repeat (100) issue_random();
        wait_idle();

        // no room to carve: only the free lists serve
        write_reg(CFG_HEAP_START, 16'($urandom_range(0, 65535)));
        write_reg(CFG_HEAP_END, 16'h0000);
        repeat (50) issue_random();
        wait_idle();

        write_reg(CFG_HEAP_END, 16'(HEAP_MID_END));
        no_idle = 1'b1;
        repeat (60) issue_random();
        no_idle = 1'b0;
        repeat (60) issue_random();
        wait_idle();

        // allocate a run of small blocks, from the lists or the break, once the heap is opened up again
        write_reg(CFG_HEAP_END, 16'hFFFF);
        repeat (30)
            issue(MODE_ALLOC, $urandom_range(0, MIN_BYTES), $urandom_range(0, 1023),
                  1'($urandom_range(0, 1)));
        repeat (3) issue(MODE_ALLOC, $urandom_range(0, MIN_BYTES), 0, 0);
        repeat (20) issue_random();
        wait_idle();

        if (failures == 0)
            $display("PASS power_of_two_bucket_allocator_core");
        else
            $display("FAIL power_of_two_bucket_allocator_core");
        $finish;
    end

endmodule
